// ===== rtl/fpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants of the framed packet parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

    // Sync byte that opens every frame.
    localparam logic [7:0] START_BYTE = 8'hAA;

    // Width of the packet_length field on the result word.
    localparam int PKT_LEN_W = 7;

    typedef enum logic [2:0] {
        ST_HUNT,    // looking for the sync byte
        ST_LEN,     // next word is the length
        ST_DATA,    // collecting payload into the store
        ST_SUM,     // next word is the checksum
        ST_REL      // streaming the stored payload out
    } t_state;

endpackage

// ===== rtl/framed_packet_parser.sv =====
// ----------------------------------------------------------------------------
// framed_packet_parser
// Sync / length / payload / checksum frame parser with a payload store.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while hunting and collecting a frame; the
//   length and checksum words also wait while the output register has no room.
//   After a good checksum of a non-empty packet the input stalls while the
//   store's single read port streams the payload out via the output register.
// Latency: an error or empty-packet result is valid the cycle after its word.
// Reset: synchronous, active low; hunting, nothing pending, store not cleared.

module framed_packet_parser #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte stream
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_status,
    output logic       o_has_byte,
    output logic [7:0] o_data,
    output logic [6:0] o_packet_length,
    output logic       o_last
);

    // Index counters must hold the length itself; addresses only the depth.
    localparam int IW  = $clog2(MAX_PAYLOAD + 1);
    localparam int AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PLW = fpp_pkg::PKT_LEN_W;

    // ---- frame state ----
    fpp_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_len,   n_len;      // expected payload length
    logic [IW-1:0]   r_idx,   n_idx;      // payload write index
    logic [7:0]      r_sum,   n_sum;      // running checksum, seeded by length

    // ---- release read pipeline ----
    logic [IW-1:0]   r_rd_cnt, n_rd_cnt;  // reads issued so far
    logic            r_rd_pend, n_rd_pend; // RAM output holds an unconsumed byte

    // ---- output register ----
    logic            r_out_valid, n_out_valid;
    logic            r_status,    n_status;
    logic            r_has_byte,  n_has_byte;
    logic [7:0]      r_data,      n_data;
    logic [PLW-1:0]  r_pkt_len,   n_pkt_len;
    logic            r_last,      n_last;

    // ---- handshake and RAM control ----
    logic            in_acc;
    logic            out_free;
    logic            load;
    logic            issue;
    logic            wr_en;
    logic            rd_en;
    logic [7:0]      rd_data;

    fpp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_cnt[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Output register is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    // Hold input while releasing, and while a word that may produce a result
    // arrives with nowhere to put it.
    assign o_in_stall = (r_state == fpp_pkg::ST_REL) ||
                        (((r_state == fpp_pkg::ST_LEN) || (r_state == fpp_pkg::ST_SUM))
                         && !out_free);
    assign in_acc = i_in_valid && !o_in_stall;

    // Release: RAM data moves to the output register when it has room; the
    // next read goes out when the RAM output is empty or being drained. No
    // write can collide with a read: the last payload write precedes the
    // checksum word, and the store is read only after it.
    assign load  = (r_state == fpp_pkg::ST_REL) && r_rd_pend && out_free;
    assign issue = (r_state == fpp_pkg::ST_REL) && (r_rd_cnt < r_len)
                   && (!r_rd_pend || load);
    assign rd_en = issue;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_rd_cnt    = r_rd_cnt;
        n_rd_pend   = issue || (r_rd_pend && !load);
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_has_byte  = r_has_byte;
        n_data      = r_data;
        n_pkt_len   = r_pkt_len;
        n_last      = r_last;
        wr_en       = 1'b0;

        unique case (r_state)
            fpp_pkg::ST_HUNT: begin
                if (in_acc && (i_rx_byte == fpp_pkg::START_BYTE)) begin
                    n_state = fpp_pkg::ST_LEN;
                end
            end
            fpp_pkg::ST_LEN: begin
                if (in_acc) begin
                    if (i_rx_byte > 8'(MAX_PAYLOAD)) begin
                        // oversize length: error result
                        n_out_valid = 1'b1;
                        n_status    = 1'b0;
                        n_has_byte  = 1'b0;
                        n_data      = 8'd0;
                        n_pkt_len   = '0;
                        n_last      = 1'b1;
                        n_state     = fpp_pkg::ST_HUNT;
                    end else begin
                        n_len   = IW'(i_rx_byte);
                        n_idx   = '0;
                        n_sum   = i_rx_byte;
                        n_state = (i_rx_byte == 8'd0) ? fpp_pkg::ST_SUM
                                                      : fpp_pkg::ST_DATA;
                    end
                end
            end
            fpp_pkg::ST_DATA: begin
                if (in_acc) begin
                    wr_en = 1'b1;
                    n_idx = IW'(r_idx + 1'b1);
                    n_sum = r_sum + i_rx_byte;
                    if (n_idx >= r_len) begin
                        n_state = fpp_pkg::ST_SUM;
                    end
                end
            end
            fpp_pkg::ST_SUM: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_has_byte  = 1'b0;
                    n_data      = 8'd0;
                    n_pkt_len   = '0;
                    n_last      = 1'b1;
                    n_state     = fpp_pkg::ST_HUNT;
                    if (i_rx_byte != r_sum) begin
                        n_status = 1'b0;
                    end else begin
                        n_status = 1'b1;
                        if (r_len != '0) begin
                            // good packet with payload: stream it instead
                            n_out_valid = r_out_valid && i_out_stall;
                            n_rd_cnt    = '0;
                            n_state     = fpp_pkg::ST_REL;
                        end
                    end
                end
            end
            fpp_pkg::ST_REL: begin
                if (issue) begin
                    n_rd_cnt = IW'(r_rd_cnt + 1'b1);
                end
                if (load) begin
                    // byte in the RAM output has index r_rd_cnt - 1
                    n_out_valid = 1'b1;
                    n_status    = 1'b1;
                    n_has_byte  = 1'b1;
                    n_data      = rd_data;
                    n_pkt_len   = PLW'(r_len);
                    n_last      = (r_rd_cnt == r_len);
                    if (r_rd_cnt == r_len) begin
                        n_state = fpp_pkg::ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = fpp_pkg::ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpp_pkg::ST_HUNT;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_sum      <= n_sum;
        r_rd_cnt   <= n_rd_cnt;
        r_status   <= n_status;
        r_has_byte <= n_has_byte;
        r_data     <= n_data;
        r_pkt_len  <= n_pkt_len;
        r_last     <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_has_byte      = r_has_byte;
    assign o_data          = r_data;
    assign o_packet_length = r_pkt_len;
    assign o_last          = r_last;

`ifndef SYNTHESIS
    // store is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("payload store written and read in one cycle");

    // a RAM byte is only pending while releasing
    a_pend_in_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == fpp_pkg::ST_REL))
        else $error("read pending outside release");

    // reads never run past the packet
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpp_pkg::ST_REL) |-> (r_rd_cnt <= r_len))
        else $error("release read count beyond packet length");

    // a non-final result is always followed by more of the same release
    a_mid_in_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == fpp_pkg::ST_REL))
        else $error("non-final result outside release");

    // leaving release happens exactly on delivering the last byte into the
    // output register
    a_rel_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fpp_pkg::ST_REL) && (n_state == fpp_pkg::ST_HUNT))
        |=> (r_out_valid && r_last && r_has_byte))
        else $error("release ended without a last payload byte");
`endif

endmodule

// ===== rtl/fpp_ram.sv =====
// ----------------------------------------------------------------------------
// fpp_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/framed_packet_parser_test.sv =====
// ----------------------------------------------------------------------------
// framed_packet_parser_test
// Self-checking bench for the sync/length/payload/checksum frame parser.
// Drives a byte stream of directed frames and then random well-formed and
// broken frames. Random gaps go on the input side and random stalls on the
// result side. Every result word is checked against a cycle-free model of
// the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module framed_packet_parser_test;

    localparam int MAX_PAYLOAD = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS = 120;

    // One result word, field by field.
    typedef struct packed {
        logic       status;
        logic       has_byte;
        logic [7:0] data;
        logic [6:0] packet_length;
        logic       last;
    } t_frame_word;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the frame the parser should be in and the result
    // words it owes us, oldest first.
    // ------------------------------------------------------------------------
    class t_packet_checker;
        fpp_pkg::t_state phase;
        int          want_len;
        int          byte_idx;
        logic [7:0]  run_sum;
        logic [7:0]  stored [MAX_PAYLOAD];
        t_frame_word awaited_words[$];
        int          bad_words;

        function new();
            phase = fpp_pkg::ST_HUNT;
            want_len = 0;
            byte_idx = 0;
            run_sum = '0;
            bad_words = 0;
        endfunction

        function void flag(string msg);
            bad_words++;
            if (bad_words <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void await_word(logic st, logic hb, logic [7:0] d, int len, logic lst);
            t_frame_word w;
            w.status = st;
            w.has_byte = hb;
            w.data = d;
            w.packet_length = len[6:0];
            w.last = lst;
            awaited_words.push_back(w);
        endfunction

        // Called for every word the parser accepts.
        function void take_rx_byte(logic [7:0] b);
            int i;
            case (phase)
                fpp_pkg::ST_HUNT: begin
                    if (b == fpp_pkg::START_BYTE)
                        phase = fpp_pkg::ST_LEN;
                end
                fpp_pkg::ST_LEN: begin
                    if (int'(b) > MAX_PAYLOAD) begin
                        await_word(1'b0, 1'b0, 8'h00, 0, 1'b1);
                        phase = fpp_pkg::ST_HUNT;
                    end else begin
                        want_len = int'(b);
                        byte_idx = 0;
                        run_sum = b;
                        phase = (b == 8'h00) ? fpp_pkg::ST_SUM : fpp_pkg::ST_DATA;
                    end
                end
                fpp_pkg::ST_DATA: begin
                    if (byte_idx < MAX_PAYLOAD)
                        stored[byte_idx] = b;
                    byte_idx++;
                    run_sum = run_sum + b;
                    if (byte_idx >= want_len)
                        phase = fpp_pkg::ST_SUM;
                end
                default: begin
                    phase = fpp_pkg::ST_HUNT;
                    if (b != run_sum) begin
                        await_word(1'b0, 1'b0, 8'h00, 0, 1'b1);
                    end else if (want_len == 0) begin
                        await_word(1'b1, 1'b0, 8'h00, 0, 1'b1);
                    end else begin
                        for (i = 0; i < want_len && i < MAX_PAYLOAD; i++)
                            await_word(1'b1, 1'b1, stored[i], want_len, i == want_len - 1);
                    end
                end
            endcase
        endfunction

        // Called for every result word the parser hands over.
        function void check_word(t_frame_word got);
            t_frame_word want;
            if (awaited_words.size() == 0) begin
                flag($sformatf("unexpected word st=%0b hb=%0b data=%h len=%0d last=%0b",
                    got.status, got.has_byte, got.data, got.packet_length, got.last));
                return;
            end
            want = awaited_words.pop_front();
            if (got !== want)
                flag($sformatf({"expected st=%0b hb=%0b data=%h len=%0d last=%0b, ",
                    "got st=%0b hb=%0b data=%h len=%0d last=%0b"},
                    want.status, want.has_byte, want.data, want.packet_length, want.last,
                    got.status, got.has_byte, got.data, got.packet_length, got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_status;
    logic       o_has_byte;
    logic [7:0] o_data;
    logic [6:0] o_packet_length;
    logic       o_last;

    framed_packet_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_has_byte     (o_has_byte),
        .o_data         (o_data),
        .o_packet_length(o_packet_length),
        .o_last         (o_last)
    );

    t_packet_checker checker_h = new();

    // When set, the matching side runs back to back with no gaps or stalls.
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    // Words accepted by the parser so far.
    int rx_count = 0;
    int cycles = 0;

    // 12 ns clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the parser hangs on either handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Called at a falling edge, returns at a falling edge. The word
    // counts once valid is high and the parser does not stall at a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        checker_h.take_rx_byte(b);
        rx_count++;
        @(negedge i_clk);
    endtask

    // One frame: sync, length, payload, checksum. A length above the maximum
    // stops after the length byte, as the parser drops back to hunting there.
    task automatic send_frame(input int len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        sum = len[7:0];
        send_byte(fpp_pkg::START_BYTE);
        send_byte(len[7:0]);
        if (len > MAX_PAYLOAD)
            return;
        for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        // XOR with a nonzero value always breaks the sum
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // Random frame mix: mostly short good packets, some empty, some long,
    // bad sums, oversize lengths and stray bytes between frames.
    task automatic send_random_frame();
        int pick;
        int len;
        int i;
        in_calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            for (i = 0; i < $urandom_range(1, 3); i++)
                send_byte(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_frame($urandom_range(MAX_PAYLOAD + 1, 255), 1'b0);
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                len = 0;
            else if (pick < 4)
                len = $urandom_range(9, MAX_PAYLOAD);
            else
                len = $urandom_range(1, 8);
            send_frame(len, $urandom_range(0, 99) < 15);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall before each word, then take the word on the
    // first rising edge with valid high.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int taken;
        t_frame_word got;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 16 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            gap = out_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.status = o_status;
            got.has_byte = o_has_byte;
            got.data = o_data;
            got.packet_length = o_packet_length;
            got.last = o_last;
            checker_h.check_word(got);
            taken++;
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Junk while hunting: no result
        send_byte(8'h00);
        send_byte(8'hFF);
        // Oversize lengths, largest and just past the limit
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'hFF);
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'd65);
        // Empty packet, good and bad checksum
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'h00);
        send_byte(8'h01);
        // Sync byte as payload, no resync: 1 + AA = AB
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'h01);
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'hAB);
        // Two-byte packet with a wrong sum (correct one would be 01)
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        // Two-byte packet whose sum wraps to 01
        send_byte(fpp_pkg::START_BYTE);
        send_byte(8'h02);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);

        // leave room for the max-size packet at the end
        while (rx_count < ITEMS - (MAX_PAYLOAD + 3))
            send_random_frame();

        // Max-size packet with a good sum
        in_calm = 1'b0;
        send_frame(MAX_PAYLOAD, 1'b0);

        i_in_valid <= 1'b0;
        while (checker_h.awaited_words.size() != 0)
            @(posedge i_clk);
        // Let anything stray come out before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_h.awaited_words.size() != 0)
            checker_h.flag("words still outstanding at end of run");

        if (checker_h.bad_words == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
